// ===== design/bcmp_pkg.sv =====
`default_nettype none

package bcmp_pkg;

   localparam int unsigned N_W = 30;
   localparam int unsigned K_W = 20;

   // prime modulus and the exponent that gives an inverse
   localparam logic [N_W-1:0] MOD     = 30'd1000000007;
   localparam logic [N_W-1:0] MOD_EXP = 30'd1000000005;

   // largest choose count taken as it stands, larger ones are clamped
   localparam int unsigned K_MAX = 1048575;

   // barrett constant, floor(2^60 / MOD)
   localparam logic [63:0] MU_FULL = (64'd1 << 60) / 64'd1000000007;
   localparam logic [30:0] MU      = MU_FULL[30:0];

   // pipeline stages of the modular multiplier
   localparam int unsigned MUL_STAGES = 6;

   typedef enum logic [2:0] {
      MUL_NUM,
      MUL_DEN,
      MUL_ACC,
      MUL_SQR,
      MUL_RES
   } mul_op_type;

   typedef struct packed {
      logic       issue;
      mul_op_type op;
      logic       pow_init;
      logic       set_zero;
      logic       publish;
   } cmd_type;

   typedef struct packed {
      logic k_gt_n;
      logic index_done;
      logic exp_zero;
      logic exp_lsb;
      logic mul_done;
      logic rsp_free;
   } status_type;

endpackage

`default_nettype wire

// ===== design/bcmp_modmul.sv =====
`default_nettype none

module bcmp_modmul (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_valid,
   input  wire logic [bcmp_pkg::N_W-1:0]   a,
   input  wire logic [bcmp_pkg::N_W-1:0]   b,
   output logic                            out_valid,
   output logic [bcmp_pkg::N_W-1:0]        r
);

   localparam logic [31:0] MOD32 = {2'b00, bcmp_pkg::MOD};

   logic [bcmp_pkg::MUL_STAGES-1:0] vld_ff;

   logic [59:0] p_in;
   logic [59:0] p_ff;
   logic [61:0] q2_in;
   logic [61:0] q2_ff;
   logic [31:0] plo1_ff;
   logic [60:0] q3m_full;
   logic [31:0] q3m_ff;
   logic [31:0] plo2_ff;
   logic [31:0] rem_ff;
   logic [31:0] rem1_ff;
   logic [31:0] rem2_ff;

   assign p_in     = a * b;
   assign q2_in    = p_ff[59:29] * bcmp_pkg::MU;
   assign q3m_full = q2_ff[61:31] * bcmp_pkg::MOD;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[bcmp_pkg::MUL_STAGES-2:0], in_valid};
      end
   end

   // barrett reduction, remainder below three moduli before the two corrections
   always_ff @(posedge clock) begin
      p_ff    <= p_in;
      q2_ff   <= q2_in;
      plo1_ff <= p_ff[31:0];
      q3m_ff  <= q3m_full[31:0];
      plo2_ff <= plo1_ff;
      rem_ff  <= plo2_ff - q3m_ff;
      rem1_ff <= (rem_ff >= MOD32) ? rem_ff - MOD32 : rem_ff;
      rem2_ff <= (rem1_ff >= MOD32) ? rem1_ff - MOD32 : rem1_ff;
   end

   assign out_valid = vld_ff[bcmp_pkg::MUL_STAGES-1];
   assign r         = rem2_ff[bcmp_pkg::N_W-1:0];

endmodule

`default_nettype wire

// ===== design/bcmp_datapath.sv =====
`default_nettype none

module bcmp_datapath #(
   parameter int unsigned K_MAX = bcmp_pkg::K_MAX
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_accept,
   input  wire logic [bcmp_pkg::N_W-1:0]   req_set_size,
   input  wire logic [bcmp_pkg::K_W-1:0]   req_choose_count,
   input  wire logic                       rsp_ready,
   output logic                            rsp_valid,
   output logic [bcmp_pkg::N_W-1:0]        rsp_coefficient,
   input  wire bcmp_pkg::cmd_type          cmd,
   output bcmp_pkg::status_type            status
);

   localparam int unsigned N_W = bcmp_pkg::N_W;
   localparam int unsigned K_W = bcmp_pkg::K_W;

   logic [K_W-1:0]       choose_ff;
   logic                 k_gt_n_ff;
   logic [K_W-1:0]       loop_index_ff;
   logic [N_W-1:0]       factor_ff;
   logic [N_W-1:0]       numerator_ff;
   logic [N_W-1:0]       denominator_ff;
   logic [N_W-1:0]       power_base_ff;
   logic [N_W-1:0]       power_exponent_ff;
   logic [N_W-1:0]       power_accumulator_ff;
   logic [N_W-1:0]       running_product_ff;
   bcmp_pkg::mul_op_type dest_ff;
   logic                 rsp_valid_ff;
   logic [N_W-1:0]       rsp_coefficient_ff;

   logic [K_W-1:0]       k_clamp;
   logic [K_W-1:0]       index_next;
   logic [N_W-1:0]       mul_a;
   logic [N_W-1:0]       mul_b;
   logic                 mul_done;
   logic [N_W-1:0]       mul_r;

   assign k_clamp    = (32'(req_choose_count) > K_MAX) ?
                       K_W'(K_MAX) : req_choose_count;
   assign index_next = loop_index_ff + 1'b1;

   always_comb begin
      case (cmd.op)
         bcmp_pkg::MUL_NUM: begin
            mul_a = numerator_ff;
            mul_b = factor_ff;
         end
         bcmp_pkg::MUL_DEN: begin
            mul_a = denominator_ff;
            mul_b = {{(N_W-K_W){1'b0}}, index_next};
         end
         bcmp_pkg::MUL_ACC: begin
            mul_a = power_accumulator_ff;
            mul_b = power_base_ff;
         end
         bcmp_pkg::MUL_SQR: begin
            mul_a = power_base_ff;
            mul_b = power_base_ff;
         end
         bcmp_pkg::MUL_RES: begin
            mul_a = numerator_ff;
            mul_b = power_accumulator_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   bcmp_modmul u_modmul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cmd.issue),
      .a         (mul_a),
      .b         (mul_b),
      .out_valid (mul_done),
      .r         (mul_r)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.publish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         choose_ff            <= k_clamp;
         k_gt_n_ff            <= {{(N_W-K_W){1'b0}}, k_clamp} > req_set_size;
         factor_ff            <= (req_set_size >= bcmp_pkg::MOD) ?
                                 req_set_size - bcmp_pkg::MOD : req_set_size;
         numerator_ff         <= N_W'(1);
         denominator_ff       <= N_W'(1);
         loop_index_ff        <= '0;
         power_accumulator_ff <= N_W'(1);
         power_exponent_ff    <= bcmp_pkg::MOD_EXP;
      end
      if (cmd.issue) begin
         dest_ff <= cmd.op;
      end
      if (cmd.pow_init) begin
         power_base_ff <= denominator_ff;
      end
      if (cmd.set_zero) begin
         running_product_ff <= '0;
      end
      if (mul_done) begin
         case (dest_ff)
            bcmp_pkg::MUL_NUM: begin
               numerator_ff <= mul_r;
            end
            bcmp_pkg::MUL_DEN: begin
               denominator_ff <= mul_r;
               loop_index_ff  <= index_next;
               // next factor n-i, wrapping below zero
               factor_ff      <= (factor_ff == '0) ? bcmp_pkg::MOD - 1'b1 :
                                 factor_ff - 1'b1;
            end
            bcmp_pkg::MUL_ACC: begin
               power_accumulator_ff <= mul_r;
            end
            bcmp_pkg::MUL_SQR: begin
               power_base_ff     <= mul_r;
               power_exponent_ff <= power_exponent_ff >> 1;
            end
            bcmp_pkg::MUL_RES: begin
               running_product_ff <= mul_r;
            end
            default: begin
            end
         endcase
      end
      if (cmd.publish) begin
         rsp_coefficient_ff <= running_product_ff;
      end
   end

   assign status.k_gt_n     = k_gt_n_ff;
   assign status.index_done = (loop_index_ff == choose_ff);
   assign status.exp_zero   = (power_exponent_ff == '0);
   assign status.exp_lsb    = power_exponent_ff[0];
   assign status.mul_done   = mul_done;
   assign status.rsp_free   = !rsp_valid_ff;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_coefficient = rsp_coefficient_ff;

endmodule

`default_nettype wire

// ===== design/bcmp_ctrl.sv =====
`default_nettype none

module bcmp_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire bcmp_pkg::status_type status,
   output bcmp_pkg::cmd_type         cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOOP,
      ST_WAIT_NUM,
      ST_WAIT_DEN,
      ST_POW,
      ST_WAIT_ACC,
      ST_WAIT_SQR,
      ST_WAIT_RES,
      ST_FINISH
   } state_type;

   state_type         state_ff;
   state_type         state_in;
   logic              ready_ff;
   logic              ready_in;
   bcmp_pkg::cmd_type cmd_ff;
   bcmp_pkg::cmd_type cmd_in;

   always_comb begin
      state_in = state_ff;
      ready_in = ready_ff;
      cmd_in   = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && ready_ff) begin
               ready_in = 1'b0;
               state_in = ST_LOOP;
            end else begin
               ready_in = 1'b1;
            end
         end
         ST_LOOP: begin
            if (status.k_gt_n) begin
               cmd_in.set_zero = 1'b1;
               state_in        = ST_FINISH;
            end else if (status.index_done) begin
               cmd_in.pow_init = 1'b1;
               state_in        = ST_POW;
            end else begin
               cmd_in.issue = 1'b1;
               cmd_in.op    = bcmp_pkg::MUL_NUM;
               state_in     = ST_WAIT_NUM;
            end
         end
         ST_WAIT_NUM: begin
            if (status.mul_done) begin
               cmd_in.issue = 1'b1;
               cmd_in.op    = bcmp_pkg::MUL_DEN;
               state_in     = ST_WAIT_DEN;
            end
         end
         ST_WAIT_DEN: begin
            if (status.mul_done) begin
               state_in = ST_LOOP;
            end
         end
         ST_POW: begin
            cmd_in.issue = 1'b1;
            if (status.exp_zero) begin
               cmd_in.op = bcmp_pkg::MUL_RES;
               state_in  = ST_WAIT_RES;
            end else if (status.exp_lsb) begin
               cmd_in.op = bcmp_pkg::MUL_ACC;
               state_in  = ST_WAIT_ACC;
            end else begin
               cmd_in.op = bcmp_pkg::MUL_SQR;
               state_in  = ST_WAIT_SQR;
            end
         end
         ST_WAIT_ACC: begin
            if (status.mul_done) begin
               cmd_in.issue = 1'b1;
               cmd_in.op    = bcmp_pkg::MUL_SQR;
               state_in     = ST_WAIT_SQR;
            end
         end
         ST_WAIT_SQR: begin
            if (status.mul_done) begin
               state_in = ST_POW;
            end
         end
         ST_WAIT_RES: begin
            if (status.mul_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.rsp_free) begin
               cmd_in.publish = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b0;
         cmd_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
         cmd_ff   <= cmd_in;
      end
   end

   assign req_ready = ready_ff;
   assign cmd       = cmd_ff;

endmodule

`default_nettype wire

// ===== design/binomial_coefficient_mod_prime_unit.sv =====
// binomial coefficient modulo the prime 1000000007
//
// req channel: one word carries set_size (n) and choose_count (k); it is
// taken when req_valid and req_ready are both high. rsp channel: one word
// per request, rsp_coefficient = C(n,k) mod 1000000007, held until taken.
// k above K_MAX is clamped; k above n gives 0, k of zero gives 1.
// each unit of k takes a loop step and two products, numerator then
// denominator, each an issue into the multiplier and six barrett stages.
// then k! is inverted by square-and-multiply over the 30 exponent bits
// (a square for each bit, with a product before it for each of the 15
// set bits), and the last product forms the result; k above n skips all
// products. every product goes through the one multiplier, one at a
// time. one request is worked at a time; the next is taken at the
// earliest while rsp_valid is first high, as req_ready rises with it.
// a finished word waits in the output register; req_ready rises again as
// soon as it is parked there, so a new request runs while the receiver
// stalls, and only its own result waits for the register to drain.
// reset (synchronous, active high) drops req_ready and rsp_valid and
// returns the controller to idle; req_ready rises in the cycle after.
`default_nettype none

module binomial_coefficient_mod_prime_unit #(
   parameter int unsigned K_MAX = bcmp_pkg::K_MAX
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [bcmp_pkg::N_W-1:0]   req_set_size,
   input  wire logic [bcmp_pkg::K_W-1:0]   req_choose_count,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [bcmp_pkg::N_W-1:0]        rsp_coefficient
);

   bcmp_pkg::cmd_type    cmd;
   bcmp_pkg::status_type status;
   logic                 req_accept;

   // request word taken at this edge
   assign req_accept = req_valid && req_ready;

   // sequencer: product loop, exponent walk, result hand-off
   bcmp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // operand registers, modular multiplier and output register
   bcmp_datapath #(
      .K_MAX (K_MAX)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_accept       (req_accept),
      .req_set_size     (req_set_size),
      .req_choose_count (req_choose_count),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_coefficient  (rsp_coefficient),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

`default_nettype wire

// ===== design/bcmp_checker.sv =====
`default_nettype none

module bcmp_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_valid,
   input wire logic                       req_ready,
   input wire logic [bcmp_pkg::N_W-1:0]   req_set_size,
   input wire logic [bcmp_pkg::K_W-1:0]   req_choose_count,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_ready,
   input wire logic [bcmp_pkg::N_W-1:0]   rsp_coefficient
);

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_coefficient))
      else $error("result word changed while stalled");

   // results are always reduced
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_coefficient < bcmp_pkg::MOD)
      else $error("result not reduced");

   // one request at a time: busy right after a request is taken
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // no word republished straight after hand-off
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> !rsp_valid)
      else $error("result word repeated");

   // a waiting request word holds until taken
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=>
         req_valid && $stable({req_set_size, req_choose_count}))
      else $error("request word changed while waiting");

endmodule

bind binomial_coefficient_mod_prime_unit bcmp_checker u_checker (.*);

`default_nettype wire

// ===== dv/tb_binomial_coefficient_mod_prime_unit.sv =====
`default_nettype none

module tb_binomial_coefficient_mod_prime_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned N_W = bcmp_pkg::N_W;
   localparam int unsigned K_W = bcmp_pkg::K_W;

   // prime and inverse exponent, widened for the predictor's products
   localparam logic [63:0] PRIME       = 64'(bcmp_pkg::MOD);
   localparam logic [63:0] PRIME_EXP   = 64'(bcmp_pkg::MOD_EXP);
   localparam int unsigned PRIME_INT   = 32'(bcmp_pkg::MOD);

   // all-ones values of the two request fields
   localparam logic [N_W-1:0] N_ALL    = '1;
   localparam logic [K_W-1:0] K_ALL    = '1;

   // one long product run
   localparam int unsigned LONG_K      = 12000;
   localparam int unsigned ITEM_CYCLES = 15 * LONG_K + 400;

   // watchdog: several times the slowest word, with every stall on top
   localparam int unsigned WATCHDOG_LIMIT = 4 * ITEM_CYCLES + 1000;

   // settle time after the last coefficient
   localparam int unsigned TAIL_CYCLES = 600;

   logic                clock            = 1'b0;
   logic                reset            = 1'b1;
   logic                req_valid        = 1'b0;
   logic                req_ready;
   logic [N_W-1:0]      req_set_size     = '0;
   logic [K_W-1:0]      req_choose_count = '0;
   logic                rsp_valid;
   logic                rsp_ready        = 1'b0;
   logic [N_W-1:0]      rsp_coefficient;

   // coefficients still owed by the block, oldest first
   logic [N_W-1:0]      coefficients_due[$];
   logic [N_W-1:0]      coefficient_wanted;

   // idling mix, in percent of cycles
   int unsigned         send_gap_pct     = 0;
   int unsigned         stall_pct        = 0;

   int unsigned         error_count      = 0;
   int unsigned         words_sent       = 0;
   int unsigned         words_checked    = 0;
   int unsigned         zero_words       = 0;
   int unsigned         largest_k_run    = 0;
   int unsigned         quiet_cycles     = 0;

   binomial_coefficient_mod_prime_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_set_size     (req_set_size),
      .req_choose_count (req_choose_count),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_coefficient  (rsp_coefficient)
   );

   // 2 ns clock
   initial begin
      forever #1 clock = ~clock;
   end

   // modular product of two residues, both below the prime
   function automatic logic [63:0] times_mod(input logic [63:0] a, input logic [63:0] b);
      return (a * b) % PRIME;
   endfunction

   // C(n,k) mod prime as the block forms it: numerator and denominator
   // gathered as products, then one inverse of k! by square-and-multiply.
   // each factor (n-i+1) is reduced on its own, so an n at or past the
   // prime is taken without any lucas split
   function automatic logic [N_W-1:0] predict_coefficient(input logic [N_W-1:0] n,
                                                           input logic [K_W-1:0] k);
      logic [63:0] numerator;
      logic [63:0] denominator;
      logic [63:0] square;
      logic [63:0] inverse;
      logic [63:0] exponent;
      int unsigned i;
      // k past n meets a zero factor
      if (k > n) begin
         return '0;
      end
      numerator   = 64'd1;
      denominator = 64'd1;
      for (i = 1; i <= k; i++) begin
         numerator   = times_mod(numerator, (64'(n) - 64'(i) + 64'd1) % PRIME);
         denominator = times_mod(denominator, 64'(i));
      end
      inverse  = 64'd1;
      square   = denominator;
      exponent = PRIME_EXP;
      while (exponent != 0) begin
         if (exponent[0]) begin
            inverse = times_mod(inverse, square);
         end
         square   = times_mod(square, square);
         exponent = exponent >> 1;
      end
      return N_W'(times_mod(numerator, inverse));
   endfunction

   // offer one request word and wait for it to be taken; valid stays high
   // on return so a back-to-back word needs no second assignment
   task automatic send_word(input logic [N_W-1:0] n, input logic [K_W-1:0] k);
      if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_gap_pct);
      end
      req_valid        <= 1'b1;
      req_set_size     <= n;
      req_choose_count <= k;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      coefficients_due = {coefficients_due, predict_coefficient(n, k)};
      words_sent++;
      if (k <= n && 32'(k) > largest_k_run) begin
         largest_k_run = 32'(k);
      end
   endtask

   // sender holds off until every owed coefficient has come back
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      while (coefficients_due.size() != 0) @(posedge clock);
   endtask

   task automatic set_idling(input int unsigned gap_pct, input int unsigned hold_pct);
      wait_until_drained();
      send_gap_pct = gap_pct;
      stall_pct    = hold_pct;
   endtask

   // empty choice, short products, k equal to n and just past it, and C(100,50)
   task automatic test_trivial_choices();
      send_word(30'd0, 20'd0);
      send_word(30'd0, 20'd1);
      send_word(30'd1, 20'd1);
      send_word(30'd5, 20'd2);
      send_word(30'd7, 20'd7);
      send_word(30'd6, 20'd7);
      send_word(30'd100, 20'd50);
   endtask

   // all-zero and all-ones fields; the large k only where k > n keeps it short
   task automatic test_field_extremes();
      send_word(N_ALL, 20'd0);
      send_word(N_ALL, 20'd1);
      send_word(N_ALL, 20'd3);
      send_word(30'd0, K_ALL);
      send_word(30'(K_ALL) - 30'd1, K_ALL);
   endtask

   // n around and past the prime: factors wrap, and one may land on zero
   task automatic test_wrap_at_modulus();
      send_word(N_W'(PRIME_INT - 1), 20'd4);
      send_word(N_W'(PRIME_INT), 20'd0);
      send_word(N_W'(PRIME_INT), 20'd1);
      send_word(N_W'(PRIME_INT + 3), 20'd5);
      send_word(N_W'(PRIME_INT + 3), 20'd3);
   endtask

   // long numerator and denominator products
   task automatic test_long_products();
      send_word(N_W'($urandom_range(PRIME_INT - 1, LONG_K)), K_W'(LONG_K));
      send_word(N_W'(2048 + $urandom_range(5000)), 20'd2048);
   endtask

   // mostly short products with random content, with wraps near the prime,
   // n past the prime, fast k > n words over the whole k range, and a few
   // medium products
   task automatic test_random_traffic(input int unsigned items);
      int unsigned     pick;
      logic [N_W-1:0]  n;
      logic [K_W-1:0]  k;
      repeat (items) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            k = K_W'($urandom_range(40));
            n = $urandom_range(1) ? N_W'($urandom()) : N_W'(k + $urandom_range(60));
         end else if (pick < 70) begin
            k = K_W'($urandom_range(48));
            n = N_W'($urandom_range(PRIME_INT + 40, PRIME_INT - 40));
         end else if (pick < 80) begin
            k = K_W'($urandom_range(32));
            n = N_W'($urandom_range(32'(N_ALL), PRIME_INT));
         end else if (pick < 92) begin
            k = K_W'($urandom_range(32'(K_ALL), 1));
            n = N_W'($urandom_range(k - 1, 0));
         end else begin
            k = K_W'($urandom_range(300, 64));
            n = N_W'($urandom());
            if (n < k) begin
               n = N_W'(k) + N_W'($urandom_range(1000));
            end
         end
         if (k > n) begin
            zero_words++;
         end
         send_word(n, k);
      end
   endtask

   // receiver: check each taken coefficient against the oldest owed one,
   // then pick ready for the next cycle
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         words_checked++;
         if (coefficients_due.size() == 0) begin
            $display("%0t: coefficient word with none owed, got %0d", $time, rsp_coefficient);
            error_count++;
         end else begin
            coefficient_wanted = coefficients_due.pop_front();
            if (rsp_coefficient !== coefficient_wanted) begin
               $display("%0t: coefficient mismatch, expected %0d, got %0d",
                        $time, coefficient_wanted, rsp_coefficient);
               error_count++;
            end
         end
      end
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // watchdog: cycles in which no word moved on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
         $display("** binomial_coefficient_mod_prime_unit: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_trivial_choices();
      test_field_extremes();
      test_wrap_at_modulus();
      test_long_products();

      // random traffic under each idling mix, drained between mixes
      set_idling(0, 0);
      test_random_traffic(70);
      set_idling(50, 0);
      test_random_traffic(70);
      set_idling(0, 50);
      test_random_traffic(70);
      set_idling(18, 18);
      test_random_traffic(70);

      wait_until_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (coefficients_due.size() != 0) begin
         $display("%0t: %0d coefficients never arrived", $time, coefficients_due.size());
         error_count++;
      end

      $display("covered %0d request words and %0d checked coefficients, %0d random k > n",
               words_sent, words_checked, zero_words);
      $display("products up to k = %0d, n past the prime, and four idling mixes", largest_k_run);
      if (error_count == 0) begin
         $display("** binomial_coefficient_mod_prime_unit: PASSED **");
      end else begin
         $display("** binomial_coefficient_mod_prime_unit: FAILED **");
      end
      $finish;
   end

endmodule

`default_nettype wire
